### rtl/lcs_pkg.sv
`timescale 1ns / 1ps
package lcs_pkg;
   localparam int NUM_LABELS_DEF = 64;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int COUNT_BITS_DEF = 32;
   localparam int LABEL_BITS     = 6;
   localparam int CFG_BITS       = 11;
   localparam int OUT_BITS       = 32;
   localparam int RATIO_BITS     = 17;

   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_TOP   = 2'd1;
   localparam logic [1:0] DIR_TR    = 2'd2;
   localparam logic [1:0] DIR_BR    = 2'd3;

   typedef struct packed {
      logic       clr_start;
      logic       clr_step;
      logic       px_start;
      logic       upd_read;
      logic       upd_write;
      logic       rd_start;
      logic       div_start;
      logic       div_step;
      logic       px_finish;
      logic       other_start;
      logic [1:0] upd_dir;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic div_done;
   } sts_type;
endpackage

### rtl/lcs_ctrl.sv
`timescale 1ns / 1ps
module lcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_kind,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lcs_pkg::cmd_type cmd,
   input  lcs_pkg::sts_type sts
);
   import lcs_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_URD   = 7'b0000100,
      ST_UWR   = 7'b0001000,
      ST_RD    = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] dir_ff, dir_in;
   logic       clr_req_ff, clr_req_in;
   logic       acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      dir_in     = dir_ff;
      clr_req_in = clr_req_ff;
      cmd        = '0;
      cmd.upd_dir = dir_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               clr_req_in = 1'b0;
               state_in = clr_req_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               case (req_kind)
                  REQ_PIXEL: begin
                     cmd.px_start = 1'b1;
                     dir_in = DIR_RIGHT;
                     state_in = ST_URD;
                  end
                  REQ_READ: begin
                     cmd.rd_start = 1'b1;
                     state_in = ST_RD;
                  end
                  REQ_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     clr_req_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     cmd.other_start = 1'b1;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_URD: begin
            cmd.upd_read = 1'b1;
            state_in = ST_UWR;
         end
         ST_UWR: begin
            cmd.upd_write = 1'b1;
            if (dir_ff == DIR_BR) begin
               cmd.px_finish = 1'b1;
               state_in = ST_OUT;
            end else begin
               dir_in = dir_ff + 2'd1;
               state_in = ST_URD;
            end
         end
         ST_RD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         dir_ff     <= DIR_RIGHT;
         clr_req_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dir_ff     <= dir_in;
         clr_req_ff <= clr_req_in;
      end
   end
endmodule

### rtl/lcs_datapath.sv
`timescale 1ns / 1ps
module lcs_datapath #(
   parameter int NUM_LABELS = lcs_pkg::NUM_LABELS_DEF,
   parameter int MAX_WIDTH  = lcs_pkg::MAX_WIDTH_DEF,
   parameter int COUNT_BITS = lcs_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lcs_pkg::CFG_BITS-1:0]   csr_image_width,
   input  logic [lcs_pkg::LABEL_BITS-1:0] in_label,
   input  logic [lcs_pkg::LABEL_BITS-1:0] in_other,
   input  logic [1:0]                     in_dir,
   input  logic                           in_first,
   input  lcs_pkg::cmd_type               cmd,
   output lcs_pkg::sts_type               sts,
   output logic [lcs_pkg::OUT_BITS-1:0]   pair_count,
   output logic [lcs_pkg::OUT_BITS-1:0]   row_total,
   output logic [lcs_pkg::RATIO_BITS-1:0] ratio,
   output logic                           saturated
);
   import lcs_pkg::*;

   localparam int LB    = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int CWB   = $clog2(MAX_WIDTH + 1);
   localparam int PAIRA = 2 + 2 * LB;
   localparam int TOTA  = 2 + LB;
   localparam int PDEP  = 1 << PAIRA;
   localparam int TDEP  = 1 << TOTA;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [LB-1:0] LMAX = LB'(NUM_LABELS - 1);

   logic [COUNT_BITS-1:0] pair_mem [PDEP];
   logic [COUNT_BITS-1:0] tot_mem [TDEP];
   logic [LB-1:0]         prev_mem [MAX_WIDTH];

   function automatic logic [LB-1:0] clampl(input logic [LABEL_BITS-1:0] v);
      if (int'(v) >= NUM_LABELS) return LMAX;
      return LB'(v);
   endfunction

   function automatic logic [OUT_BITS-1:0] out32(input logic [COUNT_BITS-1:0] v);
      if (COUNT_BITS > OUT_BITS && v > COUNT_BITS'(33'hFFFFFFFF)) return '1;
      return OUT_BITS'(v);
   endfunction

   logic [CWB-1:0] width;
   always_comb begin
      if (csr_image_width == '0) width = CWB'(1);
      else if ({1'b0, csr_image_width} > (CFG_BITS + 1)'(MAX_WIDTH)) width = CWB'(MAX_WIDTH);
      else width = CWB'(csr_image_width);
   end

   logic [CB-1:0]  col_ff, col_in;
   logic [15:0]    row_ff, row_in;
   logic [LB-1:0]  left_ff, ul_ff, lab_ff;
   logic [CB-1:0]  pcol_ff;
   logic           v_r_ff, v_t_ff, v_tr_ff, v_br_ff;
   logic [LB-1:0]  above_ff, abr_ff;
   logic           sat_ff;
   logic [PAIRA-1:0] clr_ff;
   logic [CWB-1:0]   pos;
   logic [15:0]      rpos;

   always_comb begin
      pos  = in_first ? '0 : CWB'(col_ff);
      rpos = in_first ? '0 : row_ff;
      if (pos >= width) begin
         pos = '0;
         if (rpos != 16'hFFFF) rpos = rpos + 16'd1;
      end
      col_in = CB'(pos);
      row_in = rpos;
   end

   logic [CWB-1:0] nxt;
   assign nxt = CWB'(pcol_ff) + CWB'(1);

   // address of current pair/total
   logic [LB-1:0] src, dst;
   logic          do_upd;
   always_comb begin
      src = lab_ff; dst = above_ff; do_upd = 1'b0;
      case (cmd.upd_dir)
         DIR_RIGHT: begin src = left_ff;  dst = lab_ff;   do_upd = v_r_ff;  end
         DIR_TOP:   begin src = lab_ff;   dst = above_ff; do_upd = v_t_ff;  end
         DIR_TR:    begin src = lab_ff;   dst = abr_ff;   do_upd = v_tr_ff; end
         default:   begin src = ul_ff;    dst = lab_ff;   do_upd = v_br_ff; end
      endcase
   end

   logic [PAIRA-1:0] paddr;
   logic [TOTA-1:0]  taddr;
   assign paddr = cmd.clr_step ? clr_ff :
                  (cmd.rd_start ? {in_dir, clampl(in_label), clampl(in_other)}
                                : {cmd.upd_dir, src, dst});
   assign taddr = cmd.clr_step ? TOTA'(clr_ff) :
                  (cmd.rd_start ? {in_dir, clampl(in_label)} : {cmd.upd_dir, src});

   logic [COUNT_BITS-1:0] prd_ff, trd_ff;
   logic                  pwe, twe;
   logic [COUNT_BITS-1:0] pwd, twd;

   always_comb begin
      pwe = 1'b0; twe = 1'b0; pwd = '0; twd = '0;
      if (cmd.clr_step) begin
         pwe = 1'b1;
         twe = (clr_ff < PAIRA'(TDEP));
      end else if (cmd.upd_write && do_upd) begin
         pwe = (prd_ff != CMAX);
         twe = (trd_ff != CMAX);
         pwd = prd_ff + COUNT_BITS'(1);
         twd = trd_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pwe) pair_mem[paddr] <= pwd;
      if (twe) tot_mem[taddr] <= twd;
      prd_ff <= pair_mem[paddr];
      trd_ff <= tot_mem[taddr];
   end

   // row-above line store; one read port per cycle via two phases
   logic [CB-1:0] prd_addr;
   logic [LB-1:0] prev_q;
   assign prd_addr = (cmd.upd_write && cmd.upd_dir == DIR_RIGHT) ? CB'(nxt) : pcol_ff;
   always_ff @(posedge clock) begin
      if (cmd.px_finish) prev_mem[pcol_ff] <= lab_ff;
      prev_q <= prev_mem[prd_addr];
   end

   // divider: restoring, one bit a cycle
   logic [COUNT_BITS:0]   rem_ff;
   logic [COUNT_BITS-1:0] den_ff;
   logic [RATIO_BITS:0]   q_ff;
   logic [4:0]            dcnt_ff;
   logic [COUNT_BITS:0]   sh;
   logic [COUNT_BITS-1:0] num0;
   assign num0 = (prd_ff > trd_ff) ? trd_ff : prd_ff;
   assign sh   = {rem_ff[COUNT_BITS-1:0], 1'b0};
   assign sts.div_done = cmd.div_step && (dcnt_ff == 5'd17 || den_ff == '0);
   assign sts.clr_done = (clr_ff == '1);

   logic [RATIO_BITS:0] qr;
   assign qr = q_ff + ((sh >= {1'b0, den_ff}) ? (RATIO_BITS + 1)'(1) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; left_ff <= '0; ul_ff <= '0;
         sat_ff <= 1'b0; clr_ff <= '0; dcnt_ff <= '0;
      end else begin
         if (cmd.clr_start) begin
            clr_ff <= '0;
            sat_ff <= 1'b0;
         end
         if (cmd.clr_step) clr_ff <= clr_ff + PAIRA'(1);
         if (cmd.upd_write && do_upd &&
             ((prd_ff != CMAX && pwd == CMAX) || (trd_ff != CMAX && twd == CMAX)))
            sat_ff <= 1'b1;
         if (cmd.px_start) begin
            lab_ff  <= clampl(in_label);
            pcol_ff <= col_in;
            v_r_ff  <= (col_in != '0);
            v_t_ff  <= (row_in != '0);
            v_tr_ff <= (row_in != '0) && (CWB'(col_in) + CWB'(1) < width);
            v_br_ff <= (row_in != '0) && (col_in != '0);
            row_ff  <= row_in;
         end
         if (cmd.upd_write && cmd.upd_dir == DIR_RIGHT) above_ff <= prev_q;
         if (cmd.upd_read && cmd.upd_dir == DIR_TOP) abr_ff <= prev_q;
         if (cmd.px_finish) begin
            left_ff <= lab_ff;
            ul_ff   <= v_t_ff ? above_ff : '0;
            if (nxt >= width) begin
               col_ff <= '0;
               if (row_ff != 16'hFFFF) row_ff <= row_ff + 16'd1;
            end else begin
               col_ff <= CB'(nxt);
            end
         end
         if (cmd.rd_start) begin
            pair_count <= '0; row_total <= '0; ratio <= '0;
         end
         if (cmd.div_start) begin
            pair_count <= out32(prd_ff);
            row_total  <= out32(trd_ff);
            den_ff     <= trd_ff;
            dcnt_ff    <= '0;
            if ({1'b0, num0} >= {1'b0, trd_ff}) begin
               rem_ff <= {1'b0, num0 - trd_ff};
               q_ff   <= (RATIO_BITS + 1)'(1);
            end else begin
               rem_ff <= {1'b0, num0};
               q_ff   <= '0;
            end
         end
         if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff + 5'd1;
            if (den_ff == '0) ratio <= '0;
            else if (dcnt_ff == 5'd16) begin
               ratio <= (qr > (RATIO_BITS + 1)'(65536)) ? RATIO_BITS'(65536)
                                                        : RATIO_BITS'(qr);
            end else if (sh >= {1'b0, den_ff}) begin
               rem_ff <= sh - {1'b0, den_ff};
               q_ff   <= {q_ff[RATIO_BITS-1:0], 1'b1};
            end else begin
               rem_ff <= sh;
               q_ff   <= {q_ff[RATIO_BITS-1:0], 1'b0};
            end
         end
         if (cmd.px_start || cmd.clr_start || cmd.other_start) begin
            pair_count <= '0; row_total <= '0; ratio <= '0;
         end
      end
   end

   assign saturated = sat_ff;
endmodule

### rtl/label_cooccurrence_statistics.sv
`timescale 1ns / 1ps
// Pixel word: four read-modify-write passes over the count memories, one per direction.
// Read word: paced by the one-bit-a-cycle ratio divider, which ends early on a zero total.
// Clear words run the clearing sweep before their response; other words touch no memory.
// Reset is synchronous; after it a clearing pass over all 2^(2+2*clog2(NUM_LABELS)) pair-count
// entries (16384 by default) runs before the first word is accepted.
module label_cooccurrence_statistics #(
   parameter int NUM_LABELS = lcs_pkg::NUM_LABELS_DEF,
   parameter int MAX_WIDTH  = lcs_pkg::MAX_WIDTH_DEF,
   parameter int COUNT_BITS = lcs_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // req_type, label, other_label, direction
   input  logic        req_tuser,  // first_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata   // pair_count, row_total, ratio, saturated
);
   import lcs_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [CFG_BITS-1:0] width_ff;
   logic [OUT_BITS-1:0] pc, rt;
   logic [RATIO_BITS-1:0] ra;
   logic sat;

   always_ff @(posedge clock) begin
      if (reset) width_ff <= CFG_BITS'(64);
      else if (csr_we) width_ff <= csr_wdata;
   end

   lcs_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_kind(req_tdata[1:0]), .rsp_tvalid, .rsp_tready, .cmd, .sts
   );

   lcs_datapath #(.NUM_LABELS(NUM_LABELS), .MAX_WIDTH(MAX_WIDTH),
                  .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock, .reset, .csr_image_width(width_ff),
      .in_label(req_tdata[7:2]), .in_other(req_tdata[13:8]),
      .in_dir(req_tdata[15:14]), .in_first(req_tuser),
      .cmd, .sts, .pair_count(pc), .row_total(rt), .ratio(ra), .saturated(sat)
   );

   assign rsp_tdata = {6'd0, sat, ra, rt, pc};
endmodule
